### rtl/core/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the min tracking stack
// Depth, field widths, operation and status codes, shift control struct.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;

    // result word: top, min, empty, occupancy, status, padded to bytes
    localparam int RES_W   = 2 * DATA_W + 1 + OCC_W + STAT_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W   = OUT_W - RES_W;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // one shift command for a whole chain of cells
    typedef struct packed {
        logic push;   // every cell takes its upper neighbor
        logic pop;    // every cell takes its lower neighbor
    } t_shift_ctl;

endpackage

### rtl/core/mst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_cell: one stack cell
// Holds one value; shift down on push, shift up on pop.
// ----------------------------------------------------------------------------
module mst_cell (
    input  logic                        i_clk,
    input  mst_pkg::t_shift_ctl         i_ctl,
    input  logic [mst_pkg::DATA_W-1:0]  i_above,
    input  logic [mst_pkg::DATA_W-1:0]  i_below,
    output logic [mst_pkg::DATA_W-1:0]  o_val
);

    logic [mst_pkg::DATA_W-1:0] r_val;
    logic [mst_pkg::DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.push) begin
            n_val = i_above;
        end else if (i_ctl.pop) begin
            n_val = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

### rtl/core/mst_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_chain: row of stack cells
// Cell 0 is the top; exposes the top and the entry beneath it.
// ----------------------------------------------------------------------------
module mst_chain (
    input  logic                        i_clk,
    input  mst_pkg::t_shift_ctl         i_ctl,
    input  logic [mst_pkg::DATA_W-1:0]  i_push_data,
    output logic [mst_pkg::DATA_W-1:0]  o_top,
    output logic [mst_pkg::DATA_W-1:0]  o_next
);

    logic [mst_pkg::DATA_W-1:0] w_val [mst_pkg::DEPTH];

    for (genvar g = 0; g < mst_pkg::DEPTH; g++) begin : g_cell
        logic [mst_pkg::DATA_W-1:0] w_above;
        logic [mst_pkg::DATA_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_data;
        end else begin : g_mid_above
            assign w_above = w_val[g-1];
        end

        // bottom cell keeps its contents on pop; the slot is unused afterwards
        if (g == mst_pkg::DEPTH - 1) begin : g_last
            assign w_below = w_val[g];
        end else begin : g_mid_below
            assign w_below = w_val[g+1];
        end

        mst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_val   (w_val[g])
        );
    end

    assign o_top  = w_val[0];
    assign o_next = w_val[1];

endmodule

### rtl/core/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack: stack of signed 32-bit values with running minimum
// Two shift-register chains: the value stack and the minimum stack.
// ----------------------------------------------------------------------------
// Output: a result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle; the input stalls only while a result word
//   waits in the output register and the receiver holds tready low.
// Reset: i_rst_n (synchronous, active low) clears both counts and the output
//   valid; cell contents are not cleared and are read only once written.
// ----------------------------------------------------------------------------
module min_tracking_stack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,   // [31:0] value
    input  logic                        i_s_tuser,   // [0] mode (0 push, 1 pop)
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [31:0] top_value, [63:32] min_value, [64] is_empty,
    // [71:65] occupancy, [73:72] status, [79:74] zero
    output logic [mst_pkg::OUT_W-1:0]   o_m_tdata
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [mst_pkg::CNT_W-1:0]  r_count;
    logic [mst_pkg::CNT_W-1:0]  n_count;
    logic [mst_pkg::CNT_W-1:0]  r_min_count;
    logic [mst_pkg::CNT_W-1:0]  n_min_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [mst_pkg::OUT_W-1:0]  r_out_data;
    logic [mst_pkg::OUT_W-1:0]  n_out_data;

    logic                       w_in_acc;
    mst_pkg::t_mode             w_mode;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_do_push;
    logic                       w_do_pop;
    logic                       w_min_push;
    logic                       w_min_pop;
    mst_pkg::t_shift_ctl        w_val_ctl;
    mst_pkg::t_shift_ctl        w_min_ctl;
    logic [mst_pkg::DATA_W-1:0] w_val_top;
    logic [mst_pkg::DATA_W-1:0] w_val_next;
    logic [mst_pkg::DATA_W-1:0] w_min_top;
    logic [mst_pkg::DATA_W-1:0] w_min_next;
    logic [mst_pkg::DATA_W-1:0] w_new_top;
    logic [mst_pkg::DATA_W-1:0] w_new_min;
    logic [mst_pkg::DATA_W-1:0] w_res_top;
    logic [mst_pkg::DATA_W-1:0] w_res_min;
    logic                       w_res_empty;
    mst_pkg::t_status           w_status;

    // Take a new word whenever the output register is free or draining.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_mode     = mst_pkg::t_mode'(i_s_tuser);

    assign w_full  = (r_count == mst_pkg::CNT_W'(mst_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    // Drop a push when full, ignore a pop when empty.
    assign w_do_push = w_in_acc && (w_mode == mst_pkg::MODE_PUSH) && !w_full;
    assign w_do_pop  = w_in_acc && (w_mode == mst_pkg::MODE_POP)  && !w_empty;

    // Minimum stack: push on a new low or tie, pop when the removed value is
    // the current minimum. The min count never exceeds the value count, so
    // a push that passes the full check always has room here.
    assign w_min_push = w_do_push &&
                        ((r_min_count == '0) || ($signed(i_s_tdata) <= $signed(w_min_top)));
    assign w_min_pop  = w_do_pop && (r_min_count != '0) && (w_val_top == w_min_top);

    assign w_val_ctl = '{push: w_do_push,  pop: w_do_pop};
    assign w_min_ctl = '{push: w_min_push, pop: w_min_pop};

    // ------------------------------------------------------------------
    // Cell chains
    // ------------------------------------------------------------------
    mst_chain u_val_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_val_ctl),
        .i_push_data (i_s_tdata),
        .o_top       (w_val_top),
        .o_next      (w_val_next)
    );

    mst_chain u_min_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_min_ctl),
        .i_push_data (i_s_tdata),
        .o_top       (w_min_top),
        .o_next      (w_min_next)
    );

    // ------------------------------------------------------------------
    // Counts
    // ------------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_min_count = r_min_count;
        if (w_min_push) begin
            n_min_count = r_min_count + 1'b1;
        end else if (w_min_pop) begin
            n_min_count = r_min_count - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result: tops after the operation, taken from the chain inputs
    // ------------------------------------------------------------------
    always_comb begin
        w_new_top = w_val_top;
        if (w_do_push) begin
            w_new_top = i_s_tdata;
        end else if (w_do_pop) begin
            w_new_top = w_val_next;
        end
    end

    always_comb begin
        w_new_min = w_min_top;
        if (w_min_push) begin
            w_new_min = i_s_tdata;
        end else if (w_min_pop) begin
            w_new_min = w_min_next;
        end
    end

    assign w_res_empty = (n_count == '0);
    assign w_res_top   = w_res_empty ? '0 : w_new_top;
    assign w_res_min   = (w_res_empty || (n_min_count == '0)) ? '0 : w_new_min;

    always_comb begin
        w_status = mst_pkg::ST_OK;
        case (w_mode)
            mst_pkg::MODE_PUSH: begin
                if (w_full) begin
                    w_status = mst_pkg::ST_PUSH_FULL;
                end
            end
            mst_pkg::MODE_POP: begin
                if (w_empty) begin
                    w_status = mst_pkg::ST_POP_EMPTY;
                end
            end
            default: begin
                w_status = mst_pkg::ST_OK;
            end
        endcase
    end

    // Output register: load on accept, release on downstream take.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_out_data  = {{mst_pkg::PAD_W{1'b0}},
                           w_status,
                           mst_pkg::OCC_W'(n_count),
                           w_res_empty,
                           w_res_min,
                           w_res_top};
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_min_count <= n_min_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_min_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_count <= r_count)
        else $error("minimum count exceeds value count");

    a_empty_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_min_count == '0))
        else $error("minimum stack holds entries while value stack is empty");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the stack");

    a_min_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_res_empty) |-> ($signed(w_res_min) <= $signed(w_res_top)))
        else $error("reported minimum above reported top");

endmodule

### dv/min_tracking_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb: self-checking bench for the min tracking stack
// Drives push and pop words with random gaps and back-pressure, mirrors both
// stacks in a scoreboard and checks every result word field by field.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

    // Longest legal span without any handshake is the long receiver hold.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 5000;

    // Expected content of one result word.
    typedef struct {
        logic signed [mst_pkg::DATA_W-1:0] top;
        logic signed [mst_pkg::DATA_W-1:0] minv;
        logic                              empty;
        logic [mst_pkg::OCC_W-1:0]         occ;
        mst_pkg::t_status                  status;
    } t_stack_view;

    // Mirror of the value stack and the minimum stack plus the queue of
    // result words still owed by the block.
    class t_mst_scoreboard;
        logic signed [mst_pkg::DATA_W-1:0] value_stack [mst_pkg::DEPTH];
        logic signed [mst_pkg::DATA_W-1:0] minima      [mst_pkg::DEPTH];
        int unsigned                       value_cnt;
        int unsigned                       min_cnt;
        t_stack_view                       expected_views [$];
        int                                mismatches;

        function new();
            value_cnt  = 0;
            min_cnt    = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        function logic [mst_pkg::DATA_W-1:0] current_min();
            return (min_cnt > 0) ? minima[min_cnt-1] : '0;
        endfunction

        function logic [mst_pkg::DATA_W-1:0] current_top();
            return (value_cnt > 0) ? value_stack[value_cnt-1] : '0;
        endfunction

        // Apply one accepted input word and queue the result it must produce.
        function void apply_op(mst_pkg::t_mode mode, logic signed [mst_pkg::DATA_W-1:0] value);
            t_stack_view                       view;
            logic signed [mst_pkg::DATA_W-1:0] removed;
            view.status = mst_pkg::ST_OK;
            if (mode == mst_pkg::MODE_PUSH) begin
                if (value_cnt >= mst_pkg::DEPTH) begin
                    view.status = mst_pkg::ST_PUSH_FULL;
                end else begin
                    value_stack[value_cnt] = value;
                    value_cnt++;
                    if (min_cnt == 0 || value <= minima[min_cnt-1]) begin
                        if (min_cnt < mst_pkg::DEPTH) begin
                            minima[min_cnt] = value;
                            min_cnt++;
                        end
                    end
                end
            end else begin
                if (value_cnt == 0) begin
                    view.status = mst_pkg::ST_POP_EMPTY;
                end else begin
                    removed = value_stack[value_cnt-1];
                    value_cnt--;
                    if (min_cnt > 0 && removed == minima[min_cnt-1]) min_cnt--;
                end
            end
            view.top   = (value_cnt > 0) ? value_stack[value_cnt-1] : '0;
            view.minv  = (value_cnt > 0 && min_cnt > 0) ? minima[min_cnt-1] : '0;
            view.empty = (value_cnt == 0);
            view.occ   = value_cnt[mst_pkg::OCC_W-1:0];
            expected_views.push_back(view);
        endfunction

        task report_mismatch(string what, logic [mst_pkg::DATA_W-1:0] got,
                             logic [mst_pkg::DATA_W-1:0] want);
            $display("[%0t] %s: got 0x%08h, want 0x%08h", $time, what, got, want);
            mismatches++;
        endtask

        // Compare one accepted result word against the oldest expectation.
        task check_word(logic [mst_pkg::OUT_W-1:0] word);
            t_stack_view view;
            if (expected_views.size() == 0) begin
                report_mismatch("result word with nothing pending", word[31:0], '0);
            end else begin
                view = expected_views.pop_front();
                if (word[31:0] !== view.top)
                    report_mismatch("top_value", word[31:0], view.top);
                if (word[63:32] !== view.minv)
                    report_mismatch("min_value", word[63:32], view.minv);
                if (word[64] !== view.empty)
                    report_mismatch("is_empty", 32'(word[64]), 32'(view.empty));
                if (word[71:65] !== view.occ)
                    report_mismatch("occupancy", 32'(word[71:65]), 32'(view.occ));
                if (word[73:72] !== view.status)
                    report_mismatch("status", 32'(word[73:72]), 32'(view.status));
                if (word[mst_pkg::OUT_W-1:mst_pkg::RES_W] !== '0)
                    report_mismatch("padding",
                                    32'(word[mst_pkg::OUT_W-1:mst_pkg::RES_W]), '0);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [31:0]                i_s_tdata  = '0;    // [31:0] value
    logic                       i_s_tuser  = 1'b0;  // [0] mode (0 push, 1 pop)
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    // [31:0] top_value, [63:32] min_value, [64] is_empty,
    // [71:65] occupancy, [73:72] status, [79:74] zero
    logic [mst_pkg::OUT_W-1:0]  o_m_tdata;

    min_tracking_stack i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_mst_scoreboard sb;

    // Control between the main sequence and the receiver process.
    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;
    bit rx_hold_req  = 1'b0;
    bit rx_holding   = 1'b0;

    // ------------------------------------------------------------------------
    // Monitor: check the result side first so that a word accepted on the
    // input at the same edge can never be matched against a stray result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_word(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                sb.apply_op(mst_pkg::t_mode'(i_s_tuser), i_s_tdata);
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready by default, random short stalls while enabled, and one
    // long hold on request so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                rx_holding  = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one word and hold it until the block takes it.
    task automatic send_word(mst_pkg::t_mode mode, logic [31:0] value);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop valid for a random burst of idle cycles.
    task automatic sender_gap();
        i_s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge i_clk);
    endtask

    // Wait until every result owed by the block has been taken.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Value mix: full range for bit coverage, small clustered values and the
    // current minimum or top for frequent ties, plus the signed extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: pick_value = $urandom;
            3, 4:    pick_value = 32'($signed($urandom_range(0, 8)) - 4);
            5:       pick_value = 32'($signed($urandom_range(0, 255)) - 128);
            6: begin
                case ($urandom_range(0, 3))
                    0:       pick_value = 32'h7FFF_FFFF;
                    1:       pick_value = 32'h8000_0000;
                    2:       pick_value = 32'h0000_0000;
                    default: pick_value = 32'hFFFF_FFFF;
                endcase
            end
            7, 8:    pick_value = sb.current_min();
            default: pick_value = sb.current_top();
        endcase
    endfunction

    // Random words with a given share of pushes; pop words carry junk data.
    task automatic run_random(int count, int push_pct);
        mst_pkg::t_mode mode;
        for (int n = 0; n < count; n++) begin
            if (tx_gaps_on && $urandom_range(0, 4) == 0) sender_gap();
            mode = ($urandom_range(0, 99) < push_pct) ? mst_pkg::MODE_PUSH
                                                      : mst_pkg::MODE_POP;
            send_word(mode, (mode == mst_pkg::MODE_PUSH) ? pick_value() : $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop on empty, signed extremes, ties with the minimum,
        // a value above the minimum, then unwind past empty again.
        send_word(mst_pkg::MODE_POP,  32'hFFFF_FFFF);
        send_word(mst_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_word(mst_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_word(mst_pkg::MODE_PUSH, 32'h8000_0000);
        send_word(mst_pkg::MODE_PUSH, 32'h8000_0000);
        send_word(mst_pkg::MODE_PUSH, 32'h0000_0000);
        send_word(mst_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_word(mst_pkg::MODE_PUSH, 32'h8000_0001);
        repeat (7) send_word(mst_pkg::MODE_POP, 32'h0000_0000);
        send_word(mst_pkg::MODE_POP,  32'h5555_AAAA);
        send_word(mst_pkg::MODE_PUSH, 32'd5);
        send_word(mst_pkg::MODE_PUSH, 32'd3);
        send_word(mst_pkg::MODE_PUSH, 32'd3);
        repeat (3) send_word(mst_pkg::MODE_POP, 32'hAAAA_5555);

        // Balanced traffic with gaps on both sides.
        run_random(220, 50);

        // Long receiver hold while pushes keep coming: fill the output path
        // and stall the input, then let it all flow out. Drop valid while
        // waiting for the hold so the last word is not offered twice.
        i_s_tvalid <= 1'b0;
        rx_hold_req = 1'b1;
        wait (rx_holding);
        tx_gaps_on = 1'b0;
        run_random(30, 80);
        tx_gaps_on = 1'b1;

        // Push-heavy: reach full and push against it.
        run_random(230, 85);

        // Pause the sender until every result is back.
        wait_drained();
        repeat ($urandom_range(1, 5)) @(posedge i_clk);

        // Pop-heavy: unwind to empty and pop against it.
        run_random(200, 25);

        // Final stretch: no idling on either side.
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(120, 85);
        run_random(130, 35);

        // Drain, then keep watching for stray words before the final verdict.
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
